// ===== rtl/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg - shared constants for the scalar Kalman filter unit
// Field widths, register indexes and reset values of the configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int MEAS_W      = 18;  // Q10.8 distance
  localparam int GAIN_W      = 16;  // Q0.16 gain
  localparam int VAR_W       = 32;  // Q16.16 variance
  localparam int NOISE_W     = 24;  // Q8.16 noise terms
  localparam int CFG_INDEX_W = 1;
  localparam int DEN_W       = VAR_W + 1;
  localparam int DIV_STEPS   = GAIN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = 24'd655;
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = 24'd196608;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX  = '1;
  localparam logic [MEAS_W-1:0] EST_MAX  = '1;

endpackage

`default_nettype wire

// ===== rtl/skf_in_if.sv =====
// ----------------------------------------------------------------------------
// skf_in_if - measurement channel
// Valid/ready channel carrying one distance sample and its invalid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skf_in_if;
  logic                       valid;
  logic                       ready;
  logic [skf_pkg::MEAS_W-1:0] measurement;
  logic                       invalid;

  modport source (output valid, output measurement, output invalid, input ready);
  modport sink   (input valid, input measurement, input invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/skf_out_if.sv =====
// ----------------------------------------------------------------------------
// skf_out_if - estimate channel
// Valid/ready channel carrying the filtered distance and the gain used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skf_out_if;
  logic                       valid;
  logic                       ready;
  logic [skf_pkg::MEAS_W-1:0] estimate;
  logic [skf_pkg::GAIN_W-1:0] gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink   (input valid, input estimate, input gain, output ready);
endinterface

`default_nettype wire

// ===== rtl/scalar_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit - one-dimensional Kalman filter for distances
// Sequenced datapath: one divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries a Q10.8 distance sample and an invalid flag; out_ch returns
//   one result per sample: the Q10.8 estimate and the Q0.16 gain applied.
//   cfg_wr_en/cfg_index/cfg_data write the process noise (index 0) and the
//   measurement noise (index 1); write them only while the unit is idle.
//   in_ch.ready is high only when the sequencer is idle, one sample at a time.
//   A valid sample runs from transfer to result through prediction, gain
//   setup, 16 steps of the restoring divider (one quotient bit per cycle),
//   then two passes through the shared multiplier for estimate and variance.
//   With zero measurement noise the divider is skipped. An invalid sample
//   only grows the variance and then finishes.
//   The result sits in an output register; the next sample is taken while it
//   waits, and that sample holds in its final step until out_ch.ready frees
//   the register. Synchronous reset clears estimate, variance and gain and
//   restores the default noise values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [skf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [skf_pkg::NOISE_W-1:0]       cfg_data,
  skf_in_if.sink                                 in_ch,
  skf_out_if.source                              out_ch
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_PRED   = 9'b000000010,
    ST_START  = 9'b000000100,
    ST_DIVIDE = 9'b000001000,
    ST_MULX   = 9'b000010000,
    ST_UPDX   = 9'b000100000,
    ST_MULP   = 9'b001000000,
    ST_UPDP   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  state_t                           state;
  logic [skf_pkg::NOISE_W-1:0]      q_noise;
  logic [skf_pkg::NOISE_W-1:0]      r_noise;
  logic [skf_pkg::MEAS_W-1:0]       x_est;
  logic [skf_pkg::VAR_W-1:0]        p_var;
  logic [skf_pkg::GAIN_W-1:0]       k_gain;
  logic [skf_pkg::GAIN_W-1:0]       k_new;
  logic [skf_pkg::MEAS_W-1:0]       meas;
  logic                             inv;
  logic signed [50:0]               prod;
  logic                             out_valid;
  logic [skf_pkg::MEAS_W-1:0]       out_est;
  logic [skf_pkg::GAIN_W-1:0]       out_gain;

  logic [skf_pkg::VAR_W:0]          p_sum;
  logic [skf_pkg::DEN_W-1:0]        denom;
  logic                             div_start;
  logic                             div_done;
  logic [skf_pkg::GAIN_W-1:0]       div_quo;
  logic signed [skf_pkg::MEAS_W:0]  diff;
  logic signed [17:0]               mul_a;
  logic signed [32:0]               mul_b;
  logic signed [19:0]               delta;
  logic signed [20:0]               x_sum;
  logic [skf_pkg::MEAS_W-1:0]       x_next;

  assign in_ch.ready     = (state == ST_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.estimate = out_est;
  assign out_ch.gain     = out_gain;

  always_comb begin
    p_sum     = {1'b0, p_var} + {{(skf_pkg::VAR_W + 1 - skf_pkg::NOISE_W){1'b0}}, q_noise};
    denom     = {1'b0, p_var} + {{(skf_pkg::DEN_W - skf_pkg::NOISE_W){1'b0}}, r_noise};
    div_start = (state == ST_START) && (r_noise != '0);
    diff      = $signed({1'b0, meas}) - $signed({1'b0, x_est});
    // Shared multiplier: gain times error, then (1 - gain) times variance
    if (state == ST_MULP) begin
      mul_a = 18'sd65536 - $signed({2'b00, k_new});
      mul_b = $signed({1'b0, p_var});
    end else begin
      mul_a = $signed({2'b00, k_new});
      mul_b = 33'(diff);
    end
    // Floor of the product over 2^16; the error magnitude bounds it to 20 bits
    delta = prod[35:16];
    x_sum = $signed({3'b000, x_est}) + 21'(delta);
    if (x_sum[20]) begin
      x_next = '0;
    end else if (x_sum[19:18] != 2'b00) begin
      x_next = skf_pkg::EST_MAX;
    end else begin
      x_next = x_sum[17:0];
    end
  end

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (p_var),
    .divisor  (denom),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_noise <= skf_pkg::PROCESS_NOISE_RESET;
      r_noise <= skf_pkg::MEASUREMENT_NOISE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:     q_noise <= cfg_data;
        skf_pkg::REG_MEASUREMENT_NOISE: r_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      x_est     <= '0;
      p_var     <= '0;
      k_gain    <= '0;
      out_valid <= 1'b0;
    end else begin
      // The finish step reloads the register itself
      if (out_valid && out_ch.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            meas  <= in_ch.measurement;
            inv   <= in_ch.invalid;
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          // Saturate the predicted variance
          p_var <= p_sum[skf_pkg::VAR_W] ? skf_pkg::VAR_MAX : p_sum[skf_pkg::VAR_W-1:0];
          state <= inv ? ST_FINISH : ST_START;
        end
        ST_START: begin
          if (r_noise == '0) begin
            // Gain of one saturates; zero denominator gives zero gain
            k_new <= (p_var != '0) ? skf_pkg::GAIN_MAX : '0;
            state <= ST_MULX;
          end else begin
            state <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            k_new <= div_quo;
            state <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod  <= mul_a * mul_b;
          state <= ST_UPDX;
        end
        ST_UPDX: begin
          x_est <= x_next;
          state <= ST_MULP;
        end
        ST_MULP: begin
          prod  <= mul_a * mul_b;
          state <= ST_UPDP;
        end
        ST_UPDP: begin
          p_var  <= prod[47:16];
          k_gain <= k_new;
          state  <= ST_FINISH;
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_est   <= x_est;
            out_gain  <= k_gain;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skf_div.sv =====
// ----------------------------------------------------------------------------
// skf_div - iterative restoring divider for the Kalman gain
// Produces floor(dividend * 2^16 / divisor), one quotient bit per cycle.
// The dividend must be below the divisor so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skf_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [skf_pkg::VAR_W-1:0]   dividend,
  input  wire logic [skf_pkg::DEN_W-1:0]   divisor,
  output logic                             done,
  output logic      [skf_pkg::GAIN_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(skf_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(skf_pkg::DIV_STEPS - 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [skf_pkg::DEN_W-1:0]     rem;
  logic [skf_pkg::DEN_W-1:0]     divr;
  logic [skf_pkg::DEN_W:0]       shifted;
  logic                          ge;
  logic [skf_pkg::DEN_W-1:0]     rem_next;

  always_comb begin
    shifted  = {rem, 1'b0};
    ge       = shifted >= {1'b0, divr};
    rem_next = ge ? skf_pkg::DEN_W'(shifted - {1'b0, divr})
                  : shifted[skf_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      divr     <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      quotient <= {quotient[skf_pkg::GAIN_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/skf_checker.sv =====
// ----------------------------------------------------------------------------
// skf_checker - port-level checks for the scalar Kalman filter unit
// Tracks transfers in flight and checks ordering against the channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module skf_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [skf_pkg::MEAS_W-1:0] estimate,
  input wire logic [skf_pkg::GAIN_W-1:0] gain
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Count samples taken whose result has not been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_result_has_sample: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 2'd0))
    else $error("result presented with no sample in flight");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("sample taken while another is in progress");

  a_at_most_two: assert property (@(posedge clk) disable iff (rst)
    (pending == 2'd2) |-> !in_ready)
    else $error("more than one sample queued behind a stalled result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(estimate) && $stable(gain)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_filter_unit skf_checker u_skf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .estimate  (out_ch.estimate),
  .gain      (out_ch.gain)
);

`default_nettype wire
